>>> sv/sepc_pkg.sv
// ----------------------------------------------------------------------------
// sepc_pkg: shared types and constants of the speed ellipse point classifier
// Payload structures of the query and result channels, register indexes,
// register reset values and the fixed widths of the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sepc_pkg;

	localparam int AXIS_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int RAD_W      = 32;  // vel_x^2 + vel_y^2
	localparam int ROOT_W     = 16;  // floor of its square root
	localparam int SQ_W       = 31;  // square of one signed coordinate
	localparam int SLOPE_Q_W  = 17;  // shrink term, saturated beyond this

	typedef struct packed {
		logic signed [AXIS_W-1:0] vel_x;
		logic signed [AXIS_W-1:0] vel_y;
		logic signed [AXIS_W-1:0] point_x;
		logic signed [AXIS_W-1:0] point_y;
	} query_t;

	typedef struct packed {
		logic                     is_inside;
		logic                     is_outside;
		logic                     is_on;
		logic                     degenerate;
		logic        [AXIS_W-1:0] semi_a;
		logic signed [AXIS_W-1:0] semi_b;
	} result_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_A_MIN   = 3'd0,
		CFG_A_GAIN  = 3'd1,
		CFG_B_MIN   = 3'd2,
		CFG_B_MAX   = 3'd3,
		CFG_V0      = 3'd4,
		CFG_STRETCH = 3'd5,
		CFG_TOL     = 3'd6
	} cfg_reg_t;

	localparam logic [AXIS_W-1:0] RST_A_MIN  = 16'd737;
	localparam logic [AXIS_W-1:0] RST_A_GAIN = 16'd2171;
	localparam logic [AXIS_W-1:0] RST_B_MIN  = 16'd819;
	localparam logic [AXIS_W-1:0] RST_B_MAX  = 16'd1024;
	localparam logic [AXIS_W-1:0] RST_V0     = 16'd0;
	localparam logic              RST_STRETCH = 1'b1;
	localparam logic [AXIS_W-1:0] RST_TOL    = 16'd41;

endpackage

`default_nettype wire

>>> sv/sepc_stream_if.sv
// ----------------------------------------------------------------------------
// sepc_stream_if: valid/ready channel
// Carries one payload beat per handshake; the payload type is a parameter.
// ----------------------------------------------------------------------------
`default_nettype none

interface sepc_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/speed_ellipse_point_classifier.sv
// ----------------------------------------------------------------------------
// speed_ellipse_point_classifier: speed dependent ellipse point test
// Forms the speed of a velocity vector, grows the forward semi-axis and
// shrinks the shoulder semi-axis with it, and classifies a point against
// the resulting ellipse as inside, outside or on the boundary.
// ----------------------------------------------------------------------------
//
//   channel  | dir | payload          | beat
//   ---------+-----+------------------+---------------------------------------
//   query    | in  | sepc_pkg::query_t  | velocity and point, one per beat
//   result   | out | sepc_pkg::result_t | flags and semi-axes, one per query
//   cfg      | in  | index, data      | register write when cfg_wr_en is high
//
// The block takes one query beat per cycle while its output register is empty
// or its beat is taken, and passes each through the root stages, the slope
// divider and the two quotient dividers, each retiring two bits per stage.
// The whole pipeline advances together whenever the output register is
// empty or its beat is taken, so a stall freezes every stage in place.
// Reset clears the valid bits and loads the register reset values.
//
`default_nettype none

module speed_ellipse_point_classifier #(
	parameter int FRAC_BITS = 12
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	sepc_stream_if.sink                            query,
	sepc_stream_if.source                          result,
	input  wire logic                              cfg_wr_en,
	input  wire logic [sepc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [sepc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int AW    = sepc_pkg::AXIS_W;
	localparam int SQW   = sepc_pkg::SQ_W;
	localparam int RTW   = sepc_pkg::ROOT_W;
	localparam int SQQW  = sepc_pkg::SLOPE_Q_W;
	// Shrinking is off while desired_speed is at or below one thousandth.
	localparam logic [AW-1:0] V0_MIN = AW'((1 << FRAC_BITS) / 1000);
	// Quotient width that still tells the widest on band from far outside.
	localparam int TQW   = ((FRAC_BITS > AW) ? FRAC_BITS : AW) + 2;
	localparam int TNW   = SQW + FRAC_BITS;
	localparam logic [TQW:0] ONE = (TQW+1)'(1) << FRAC_BITS;
	localparam logic signed [18:0] B_HI = 19'sd32767;
	localparam logic signed [18:0] B_LO = -19'sd32768;

	// ------------------------------------------------------------------
	// Configuration registers, for the user to write only while idle; the
	// block does not enforce it. The datapath reads them where needed.
	// ------------------------------------------------------------------
	logic [AW-1:0] a_min_q, a_gain_q, b_min_q, b_max_q, v0_q, tol_q;
	logic          stretch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_min_q   <= sepc_pkg::RST_A_MIN;
			a_gain_q  <= sepc_pkg::RST_A_GAIN;
			b_min_q   <= sepc_pkg::RST_B_MIN;
			b_max_q   <= sepc_pkg::RST_B_MAX;
			v0_q      <= sepc_pkg::RST_V0;
			stretch_q <= sepc_pkg::RST_STRETCH;
			tol_q     <= sepc_pkg::RST_TOL;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				sepc_pkg::CFG_A_MIN:   a_min_q   <= cfg_data;
				sepc_pkg::CFG_A_GAIN:  a_gain_q  <= cfg_data;
				sepc_pkg::CFG_B_MIN:   b_min_q   <= cfg_data;
				sepc_pkg::CFG_B_MAX:   b_max_q   <= cfg_data;
				sepc_pkg::CFG_V0:      v0_q      <= cfg_data;
				sepc_pkg::CFG_STRETCH: stretch_q <= cfg_data[0];
				sepc_pkg::CFG_TOL:     tol_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Global advance: all stages move when the output beat is absent or taken.
	// ------------------------------------------------------------------
	logic              out_v_q;
	sepc_pkg::result_t res_q;
	logic              adv;

	assign adv         = !out_v_q || result.ready;
	assign query.ready = adv;

	// ------------------------------------------------------------------
	// Stage 1: squares of the velocity and point coordinates.
	// ------------------------------------------------------------------
	logic signed [31:0] vx2_c, vy2_c, px2_c, py2_c;
	logic               v_s1;
	logic [31:0]        rad_s1;
	logic [SQW-1:0]     px2_s1, py2_s1;

	assign vx2_c = query.data.vel_x * query.data.vel_x;
	assign vy2_c = query.data.vel_y * query.data.vel_y;
	assign px2_c = query.data.point_x * query.data.point_x;
	assign py2_c = query.data.point_y * query.data.point_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= query.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s1 <= $unsigned(vx2_c) + $unsigned(vy2_c);
			px2_s1 <= px2_c[SQW-1:0];
			py2_s1 <= py2_c[SQW-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Speed: pipelined integer square root.
	// ------------------------------------------------------------------
	logic             sq_v;
	logic [RTW-1:0]   speed;
	logic [2*SQW-1:0] sq_sb;

	sepc_sqrt #(.SBW(2 * SQW)) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s1),
		.in_rad    (rad_s1),
		.in_sb     ({px2_s1, py2_s1}),
		.out_valid (sq_v),
		.out_root  (speed),
		.out_sb    (sq_sb)
	);

	// ------------------------------------------------------------------
	// Stage 2: speed times gain and speed times |b_max - b_min|.
	// ------------------------------------------------------------------
	logic [AW:0]    b_diff_c;
	logic [AW-1:0]  b_dmag_c;
	logic           b_neg_c;
	logic           v_s2;
	logic [31:0]    prod_a_s2, prod_d_s2;
	logic [SQW-1:0] px2_s2, py2_s2;

	assign b_diff_c = {1'b0, b_max_q} - {1'b0, b_min_q};
	assign b_neg_c  = b_diff_c[AW];
	assign b_dmag_c = b_neg_c ? AW'(-b_diff_c) : b_diff_c[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= sq_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_a_s2 <= speed * a_gain_q;
			prod_d_s2 <= speed * b_dmag_c;
			px2_s2    <= sq_sb[2*SQW-1:SQW];
			py2_s2    <= sq_sb[SQW-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: forward semi-axis, saturated to its field.
	// ------------------------------------------------------------------
	logic [32:0]    a_sum_c;
	logic           v_s3;
	logic [AW-1:0]  a_s3;
	logic [31:0]    prod_d_s3;
	logic [SQW-1:0] px2_s3, py2_s3;

	assign a_sum_c = 33'(a_min_q) + 33'(prod_a_s2 >> FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s3      <= (a_sum_c > 33'(16'hFFFF)) ? '1 : a_sum_c[AW-1:0];
			prod_d_s3 <= prod_d_s2;
			px2_s3    <= px2_s2;
			py2_s3    <= py2_s2;
		end
	end

	// ------------------------------------------------------------------
	// Shrink term |speed*(b_max-b_min)| / desired_speed. A quotient too
	// large for SLOPE_Q_W bits saturates, which drives b to its limit.
	// ------------------------------------------------------------------
	logic                  qd_v;
	logic [SQQW-1:0]       qd_quo;
	logic [2*SQW+AW-1:0]   qd_sb;

	sepc_div #(.NW(32), .DW(AW), .QW(SQQW), .SPS(2), .SBW(2 * SQW + AW)) u_slope_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s3),
		.in_num    (prod_d_s3),
		.in_den    (v0_q),
		.in_sb     ({px2_s3, py2_s3, a_s3}),
		.out_valid (qd_v),
		.out_quo   (qd_quo),
		.out_sb    (qd_sb)
	);

	// ------------------------------------------------------------------
	// Stage 4: shoulder semi-axis with saturation, and a^2.
	// ------------------------------------------------------------------
	logic signed [18:0] b_raw_c;
	logic [AW-1:0]      a_c;
	logic               v_s4;
	logic [AW-1:0]      a_s4;
	logic signed [AW-1:0] b_s4;
	logic [31:0]        a2_s4;
	logic [SQW-1:0]     px2_s4, py2_s4;

	assign a_c = qd_sb[AW-1:0];

	always_comb begin
		if (!stretch_q) begin
			b_raw_c = $signed({3'b000, b_min_q});
		end else if (v0_q > V0_MIN) begin
			// The shrink term takes the sign of b_max - b_min.
			if (b_neg_c) begin
				b_raw_c = $signed({3'b000, b_max_q}) + $signed({2'b00, qd_quo});
			end else begin
				b_raw_c = $signed({3'b000, b_max_q}) - $signed({2'b00, qd_quo});
			end
		end else begin
			b_raw_c = $signed({3'b000, b_max_q});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= qd_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s4   <= a_c;
			a2_s4  <= a_c * a_c;
			px2_s4 <= qd_sb[2*SQW+AW-1:SQW+AW];
			py2_s4 <= qd_sb[SQW+AW-1:AW];
			if (b_raw_c > B_HI) begin
				b_s4 <= 16'sh7FFF;
			end else if (b_raw_c < B_LO) begin
				b_s4 <= 16'sh8000;
			end else begin
				b_s4 <= b_raw_c[AW-1:0];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: b^2 and the zero axis check.
	// ------------------------------------------------------------------
	logic signed [31:0]   b2_c;
	logic                 v_s5;
	logic [AW-1:0]        a_s5;
	logic signed [AW-1:0] b_s5;
	logic [31:0]          a2_s5, b2_s5;
	logic                 degen_s5;
	logic [SQW-1:0]       px2_s5, py2_s5;

	assign b2_c = b_s4 * b_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s5     <= a_s4;
			b_s5     <= b_s4;
			a2_s5    <= a2_s4;
			b2_s5    <= $unsigned(b2_c);
			degen_s5 <= (a_s4 == '0) || (b_s4 == '0);
			px2_s5   <= px2_s4;
			py2_s5   <= py2_s4;
		end
	end

	// ------------------------------------------------------------------
	// tx = x^2*2^F / a^2 and ty = y^2*2^F / b^2, side by side. Saturated
	// quotients still read as clearly outside.
	// ------------------------------------------------------------------
	logic           tx_v, ty_v;
	logic [TQW-1:0] tx, ty;
	logic [2*AW-1:0] tx_sb;
	logic           ty_degen;

	sepc_div #(.NW(TNW), .DW(32), .QW(TQW), .SPS(2), .SBW(2 * AW)) u_tx_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s5),
		.in_num    ({px2_s5, {FRAC_BITS{1'b0}}}),
		.in_den    (a2_s5),
		.in_sb     ({a_s5, b_s5}),
		.out_valid (tx_v),
		.out_quo   (tx),
		.out_sb    (tx_sb)
	);

	sepc_div #(.NW(TNW), .DW(32), .QW(TQW), .SPS(2), .SBW(1)) u_ty_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s5),
		.in_num    ({py2_s5, {FRAC_BITS{1'b0}}}),
		.in_den    (b2_s5),
		.in_sb     (degen_s5),
		.out_valid (ty_v),
		.out_quo   (ty),
		.out_sb    (ty_degen)
	);

	// ------------------------------------------------------------------
	// Classification into the output register.
	// ------------------------------------------------------------------
	logic [TQW:0]      sum_c, mag_c;
	sepc_pkg::result_t res_c;

	assign sum_c = {1'b0, tx} + {1'b0, ty};
	assign mag_c = (sum_c > ONE) ? (sum_c - ONE) : (ONE - sum_c);

	always_comb begin
		res_c            = '0;
		res_c.semi_a     = tx_sb[2*AW-1:AW];
		res_c.semi_b     = tx_sb[AW-1:0];
		res_c.degenerate = ty_degen;
		if (!ty_degen) begin
			res_c.is_inside  = sum_c < ONE;
			res_c.is_outside = sum_c > ONE;
			res_c.is_on      = mag_c < (TQW+1)'(tol_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= tx_v && ty_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_c;
		end
	end

	assign result.valid = out_v_q;
	assign result.data  = res_q;

endmodule

`default_nettype wire

>>> sv/sepc_sqrt.sv
// ----------------------------------------------------------------------------
// sepc_sqrt: pipelined integer square root
// Digit-by-digit root of a 32-bit radicand, two root bits per stage, with a
// sideband word and a valid bit travelling alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module sepc_sqrt #(
	parameter int SBW = 1
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_valid,
	input  wire logic [sepc_pkg::RAD_W-1:0]    in_rad,
	input  wire logic [SBW-1:0]                in_sb,
	output logic                               out_valid,
	output logic [sepc_pkg::ROOT_W-1:0]        out_root,
	output logic [SBW-1:0]                     out_sb
);

	localparam int RW  = sepc_pkg::RAD_W;
	localparam int QW  = sepc_pkg::ROOT_W;
	localparam int SPS = 2;
	localparam int NST = (QW + SPS - 1) / SPS;
	localparam int TW  = RW + 2;

	logic          v_s    [NST];
	logic [RW-1:0] rem_s  [NST];
	logic [QW-1:0] root_s [NST];
	logic [SBW-1:0] sb_s  [NST];

	for (genvar st = 0; st < NST; st++) begin : g_stage
		logic           v_c;
		logic [RW-1:0]  rem_c, rem_n;
		logic [QW-1:0]  root_c, root_n;
		logic [SBW-1:0] sb_c;

		if (st == 0) begin : g_head
			assign v_c    = in_valid;
			assign rem_c  = in_rad;
			assign root_c = '0;
			assign sb_c   = in_sb;
		end else begin : g_body
			assign v_c    = v_s[st-1];
			assign rem_c  = rem_s[st-1];
			assign root_c = root_s[st-1];
			assign sb_c   = sb_s[st-1];
		end

		// Try to set root bit bi: (r + 2^bi)^2 - r^2 = r*2^(bi+1) + 2^(2*bi).
		always_comb begin
			logic [TW-1:0] trial;
			int            bi;
			rem_n  = rem_c;
			root_n = root_c;
			trial  = '0;
			bi     = 0;
			for (int k = 0; k < SPS; k++) begin
				bi = QW - 1 - (st * SPS + k);
				if (bi >= 0) begin
					trial = ({{(TW-QW){1'b0}}, root_n} << (bi + 1)) + (TW'(1) << (2 * bi));
					if ({{(TW-RW){1'b0}}, rem_n} >= trial) begin
						rem_n  = rem_n - trial[RW-1:0];
						root_n = root_n | (QW'(1) << bi);
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[st] <= 1'b0;
			end else if (en) begin
				v_s[st] <= v_c;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[st]  <= rem_n;
				root_s[st] <= root_n;
				sb_s[st]   <= sb_c;
			end
		end
	end

	assign out_valid = v_s[NST-1];
	assign out_root  = root_s[NST-1];
	assign out_sb    = sb_s[NST-1];

endmodule

`default_nettype wire

>>> sv/sepc_div.sv
// ----------------------------------------------------------------------------
// sepc_div: pipelined saturating unsigned divider
// Restoring long division, a few quotient bits per stage. A quotient that
// does not fit in QW bits comes out as all ones.
// ----------------------------------------------------------------------------
`default_nettype none

module sepc_div #(
	parameter int NW  = 32,
	parameter int DW  = 16,
	parameter int QW  = 17,
	parameter int SPS = 2,
	parameter int SBW = 1
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_valid,
	input  wire logic [NW-1:0]  in_num,
	input  wire logic [DW-1:0]  in_den,
	input  wire logic [SBW-1:0] in_sb,
	output logic                out_valid,
	output logic [QW-1:0]       out_quo,
	output logic [SBW-1:0]      out_sb
);

	localparam int CW  = ((NW > DW + QW) ? NW : DW + QW) + 1;
	localparam int NST = (QW + SPS - 1) / SPS;

	logic           v_s   [NST];
	logic           ovf_s [NST];
	logic [CW-1:0]  rem_s [NST];
	logic [DW-1:0]  den_s [NST];
	logic [QW-1:0]  quo_s [NST];
	logic [SBW-1:0] sb_s  [NST];

	for (genvar st = 0; st < NST; st++) begin : g_stage
		logic           v_c, ovf_c;
		logic [CW-1:0]  rem_c, rem_n;
		logic [DW-1:0]  den_c;
		logic [QW-1:0]  quo_c, quo_n;
		logic [SBW-1:0] sb_c;

		if (st == 0) begin : g_head
			assign v_c   = in_valid;
			assign rem_c = {{(CW-NW){1'b0}}, in_num};
			assign den_c = in_den;
			assign quo_c = '0;
			assign sb_c  = in_sb;
			assign ovf_c = ({{(CW-NW){1'b0}}, in_num} >= ({{(CW-DW){1'b0}}, in_den} << QW));
		end else begin : g_body
			assign v_c   = v_s[st-1];
			assign rem_c = rem_s[st-1];
			assign den_c = den_s[st-1];
			assign quo_c = quo_s[st-1];
			assign sb_c  = sb_s[st-1];
			assign ovf_c = ovf_s[st-1];
		end

		always_comb begin
			logic [CW-1:0] trial;
			int            bi;
			rem_n = rem_c;
			quo_n = quo_c;
			trial = '0;
			bi    = 0;
			for (int k = 0; k < SPS; k++) begin
				bi = QW - 1 - (st * SPS + k);
				if (bi >= 0) begin
					trial = {{(CW-DW){1'b0}}, den_c} << bi;
					if (rem_n >= trial) begin
						rem_n = rem_n - trial;
						quo_n = quo_n | (QW'(1) << bi);
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[st] <= 1'b0;
			end else if (en) begin
				v_s[st] <= v_c;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ovf_s[st] <= ovf_c;
				rem_s[st] <= rem_n;
				den_s[st] <= den_c;
				quo_s[st] <= quo_n;
				sb_s[st]  <= sb_c;
			end
		end
	end

	assign out_valid = v_s[NST-1];
	assign out_quo   = ovf_s[NST-1] ? '1 : quo_s[NST-1];
	assign out_sb    = sb_s[NST-1];

endmodule

`default_nettype wire

>>> sv/sepc_check.sv
// ----------------------------------------------------------------------------
// sepc_check: result channel checker
// Watches the result port of the classifier for consistent flags and for a
// beat that holds while stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module sepc_check (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              res_valid,
	input wire logic              res_ready,
	input wire sepc_pkg::result_t res_data
);

	// A degenerate ellipse reports no classification at all.
	a_degen_clears: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.degenerate |->
			!res_data.is_inside && !res_data.is_outside && !res_data.is_on)
		else $error("degenerate result carries classification flags");

	// Inside and outside exclude each other.
	a_side_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res_data.is_inside && res_data.is_outside))
		else $error("result is both inside and outside");

	// The degenerate flag follows exactly from the reported axes.
	a_degen_axes: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |->
			(res_data.degenerate == ((res_data.semi_a == '0) || (res_data.semi_b == '0))))
		else $error("degenerate flag disagrees with semi-axes");

	// A stalled result beat holds.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result beat changed while stalled");

endmodule

bind speed_ellipse_point_classifier sepc_check u_sepc_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_data  (result.data)
);

`default_nettype wire

>>> bench/speed_ellipse_point_classifier_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// speed_ellipse_point_classifier_tb: self-checking bench of the ellipse test
// The bench drives velocity and point queries through the query channel in
// random bursts, while the result channel stalls on its own pattern. Every
// accepted query is classified by an in-bench model of the speed, the two
// semi-axes and the implicit ellipse value, and each returned beat is
// compared field by field against the oldest pending prediction. A short
// directed table covers the extremes and corner cases first. Random phases
// with varied register settings follow.
// ----------------------------------------------------------------------------
`default_nettype none

module speed_ellipse_point_classifier_tb;

	localparam int HALF_PERIOD = 4;
	localparam int RESET_CYCLES = 12;
	localparam int PIPE_DRAIN = 40;
	localparam int STALL_LIMIT = 5000;   // cycles without any beat moving
	localparam int LONG_HOLD = 150;      // receiver hold-off, fills the pipe
	localparam int RANDOM_PER_PHASE = 168;
	localparam int MAX_REPORTS = 10;
	localparam logic [sepc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [sepc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [sepc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	sepc_stream_if #(.T(sepc_pkg::query_t)) query_ch ();
	sepc_stream_if #(.T(sepc_pkg::result_t)) result_ch ();

	speed_ellipse_point_classifier DUT (
		.clk(clk),
		.arst_n(arst_n),
		.query(query_ch),
		.result(result_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Mirror of the register file, updated whenever the bench writes it.
	logic [15:0] a_min, a_gain, b_min, b_max, v0, tol;
	logic stretch;

	// Predictions waiting for their result beat, oldest first.
	sepc_pkg::result_t pending_results[$];
	int mismatches = 0;
	int queries_sent = 0;
	bit query_took = 1'b0;

	// The payload that goes with the query currently offered. When a row of
	// the directed table carries a hand-typed result, that one is queued in
	// place of the prediction.
	bit offer_typed = 1'b0;
	sepc_pkg::result_t offer_expect;

	// Floor of the square root; the sum of two squares stays below 2^32,
	// so the root fits in 16 bits.
	function automatic longint floor_root(longint n);
		longint r;
		r = 0;
		for (int bitpos = 15; bitpos >= 0; bitpos--) begin
			if ((r | (64'd1 << bitpos)) * (r | (64'd1 << bitpos)) <= n)
				r = r | (64'd1 << bitpos);
		end
		return r;
	endfunction

	// Classifies one query against the ellipse of the current settings.
	function automatic sepc_pkg::result_t classify_point(sepc_pkg::query_t q);
		longint vx, vy, px, py, spd, sa, sb, shrink, tx, ty, cnd, mag;
		sepc_pkg::result_t r;
		vx = q.vel_x;
		vy = q.vel_y;
		px = q.point_x;
		py = q.point_y;
		spd = floor_root(vx * vx + vy * vy);
		sa = longint'(a_min) + ((spd * longint'(a_gain)) >>> 12);
		if (sa > 65535)
			sa = 65535;
		if (stretch) begin
			shrink = 0;
			// A desired speed of four or less counts as zero and keeps b fixed.
			if (v0 > 16'd4)
				shrink = (spd * (longint'(b_max) - longint'(b_min))) / longint'(v0);
			sb = longint'(b_max) - shrink;
		end else begin
			sb = b_min;
		end
		if (sb > 32767)
			sb = 32767;
		if (sb < -32768)
			sb = -32768;
		r = '0;
		r.semi_a = sa[15:0];
		r.semi_b = sb[15:0];
		r.degenerate = (sa == 0) || (sb == 0);
		if (!r.degenerate) begin
			tx = ((px * px) <<< 12) / (sa * sa);
			ty = ((py * py) <<< 12) / (sb * sb);
			cnd = tx + ty - 4096;
			mag = (cnd < 0) ? -cnd : cnd;
			r.is_inside = cnd < 0;
			r.is_outside = cnd > 0;
			r.is_on = mag < longint'(tol);
		end
		return r;
	endfunction

	// Posedge monitor: records query beats with their prediction and checks
	// result beats. Values read here are the ones from before the edge.
	always @(posedge clk) begin
		sepc_pkg::result_t want;
		query_took <= query_ch.valid && query_ch.ready;
		if (query_ch.valid && query_ch.ready)
			pending_results.push_back(offer_typed ? offer_expect :
				classify_point(query_ch.data));
		if (result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("result beat with nothing pending: %p", result_ch.data);
			end else begin
				want = pending_results.pop_front();
				if (want.is_inside !== result_ch.data.is_inside ||
						want.is_outside !== result_ch.data.is_outside ||
						want.is_on !== result_ch.data.is_on ||
						want.degenerate !== result_ch.data.degenerate ||
						want.semi_a !== result_ch.data.semi_a ||
						want.semi_b !== result_ch.data.semi_b) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("result mismatch: expected %p, got %p", want,
							result_ch.data);
				end
			end
		end
	end

	// Watchdog: a hung handshake on either side ends the run.
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((query_ch.valid && query_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Receiver: switches between always ready, mostly ready and mostly
	// stalled, and once holds off for a long stretch so the pipeline fills
	// and pushes back on the query side.
	initial begin
		int mode_left;
		int mode;
		bit long_hold_done;
		result_ch.ready = 1'b0;
		mode_left = 0;
		mode = 0;
		long_hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!long_hold_done && queries_sent >= 300) begin
				long_hold_done = 1'b1;
				result_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end
			if (mode_left == 0) begin
				mode = $urandom_range(2, 0);
				mode_left = $urandom_range(64, 16);
			end
			mode_left--;
			case (mode)
				0: result_ch.ready <= 1'b1;
				1: result_ch.ready <= ($urandom_range(3, 0) != 0);
				default: result_ch.ready <= ($urandom_range(9, 0) < 3);
			endcase
		end
	end

	// Sender burst pacing.
	int burst_left = 0;

	task automatic wait_drained();
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	// Offers one query beat and returns once it has been taken. Valid stays
	// high into the next beat unless a gap between bursts falls here.
	task automatic offer_query(sepc_pkg::query_t q, bit typed, sepc_pkg::result_t want);
		if (burst_left == 0) begin
			burst_left = $urandom_range(20, 1);
			if ($urandom_range(3, 0) != 0) begin
				query_ch.valid <= 1'b0;
				repeat ($urandom_range(6, 1)) @(negedge clk);
			end
		end
		burst_left--;
		query_ch.valid <= 1'b1;
		query_ch.data <= q;
		offer_typed <= typed;
		offer_expect <= want;
		do
			@(negedge clk);
		while (!query_took);
		queries_sent++;
	endtask

	// Writes a register with the block idle. The query side goes quiet, every
	// pending result is collected and the pipeline gets its latency to settle.
	task automatic write_register(logic [sepc_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
		query_ch.valid <= 1'b0;
		wait_drained();
		repeat (PIPE_DRAIN) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			sepc_pkg::CFG_A_MIN: a_min = val;
			sepc_pkg::CFG_A_GAIN: a_gain = val;
			sepc_pkg::CFG_B_MIN: b_min = val;
			sepc_pkg::CFG_B_MAX: b_max = val;
			sepc_pkg::CFG_V0: v0 = val;
			sepc_pkg::CFG_STRETCH: stretch = val[0];
			sepc_pkg::CFG_TOL: tol = val;
			default: ;  // unused index, nothing changes
		endcase
	endtask

	task automatic load_settings(logic [15:0] amin, logic [15:0] again, logic [15:0] bmin,
			logic [15:0] bmax, logic [15:0] dspeed, logic st, logic [15:0] band);
		write_register(sepc_pkg::CFG_A_MIN, amin);
		write_register(sepc_pkg::CFG_A_GAIN, again);
		write_register(sepc_pkg::CFG_B_MIN, bmin);
		write_register(sepc_pkg::CFG_B_MAX, bmax);
		write_register(sepc_pkg::CFG_V0, dspeed);
		write_register(sepc_pkg::CFG_STRETCH, {15'd0, st});
		write_register(sepc_pkg::CFG_TOL, band);
	endtask

	// Random queries. Most points are drawn around the current ellipse so
	// that inside, outside and boundary hits all come up; the rest, and some
	// velocities, cover the whole 16-bit range.
	task automatic random_queries(int count);
		sepc_pkg::query_t q;
		sepc_pkg::result_t axes;
		longint span_a, span_b;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(3, 0) == 0) begin
				q.vel_x = 16'($urandom);
				q.vel_y = 16'($urandom);
			end else begin
				q.vel_x = $signed(16'($urandom_range(16383, 0))) - 16'sd8192;
				q.vel_y = $signed(16'($urandom_range(8191, 0))) - 16'sd4096;
			end
			q.point_x = '0;
			q.point_y = '0;
			axes = classify_point(q);
			if ($urandom_range(9, 0) < 4) begin
				q.point_x = 16'($urandom);
				q.point_y = 16'($urandom);
			end else begin
				span_a = longint'(axes.semi_a) + longint'(axes.semi_a) / 8 + 1;
				span_b = longint'(axes.semi_b < 0 ? -axes.semi_b : axes.semi_b);
				span_b = span_b + span_b / 8 + 1;
				if (span_a > 32767)
					span_a = 32767;
				if (span_b > 32767)
					span_b = 32767;
				q.point_x = 16'(longint'($urandom_range(2 * span_a, 0)) - span_a);
				q.point_y = 16'(longint'($urandom_range(2 * span_b, 0)) - span_b);
			end
			offer_query(q, 1'b0, '0);
		end
	endtask

	// Directed table: either a register write or a query, the latter with a
	// hand-typed result where it follows plainly from the settings.
	typedef struct {
		bit is_write;
		logic [sepc_pkg::CFG_IDX_W-1:0] idx;
		logic [15:0] val;
		sepc_pkg::query_t q;
		bit typed;
		sepc_pkg::result_t want;
	} step_row_t;

	function automatic step_row_t qrow(int vx, int vy, int px, int py);
		step_row_t r;
		r = '{default: '0};
		r.q = '{vel_x: 16'(vx), vel_y: 16'(vy), point_x: 16'(px), point_y: 16'(py)};
		return r;
	endfunction

	function automatic step_row_t trow(int vx, int vy, int px, int py, logic [3:0] flags,
			int sa, int sb);
		step_row_t r;
		r = qrow(vx, vy, px, py);
		r.typed = 1'b1;
		r.want = '{is_inside: flags[3], is_outside: flags[2], is_on: flags[1],
			degenerate: flags[0], semi_a: 16'(sa), semi_b: 16'(sb)};
		return r;
	endfunction

	function automatic step_row_t wrow(logic [sepc_pkg::CFG_IDX_W-1:0] idx, int val);
		step_row_t r;
		r = '{default: '0};
		r.is_write = 1'b1;
		r.idx = idx;
		r.val = 16'(val);
		return r;
	endfunction

	step_row_t directed[$];

	initial begin
		query_ch.valid = 1'b0;
		query_ch.data = '0;
		a_min = sepc_pkg::RST_A_MIN;
		a_gain = sepc_pkg::RST_A_GAIN;
		b_min = sepc_pkg::RST_B_MIN;
		b_max = sepc_pkg::RST_B_MAX;
		v0 = sepc_pkg::RST_V0;
		stretch = sepc_pkg::RST_STRETCH;
		tol = sepc_pkg::RST_TOL;

		// Flag order in the typed rows: inside, outside, on, degenerate.
		// At reset a is 737 and b is 1024, since the desired speed is zero.
		directed = '{
			trow(0, 0, 0, 0, 4'b1000, 737, 1024),
			// Exactly on the forward vertex and the shoulder vertex.
			trow(0, 0, 737, 0, 4'b0010, 737, 1024),
			trow(0, 0, 0, -1024, 4'b0010, 737, 1024),
			// One step past the vertex is outside but still within the band.
			trow(0, 0, 738, 0, 4'b0110, 737, 1024),
			qrow(0, 0, -32768, -32768),
			qrow(32767, 32767, 32767, -32768),
			qrow(-32768, -32768, 1, -1),
			qrow(-32768, 0, 20000, 0),
			qrow(0, -32768, 0, 1000),
			qrow(1, 1, -1, 1),
			// Just above the slope threshold the shoulder axis shrinks past zero.
			wrow(sepc_pkg::CFG_V0, 5),
			qrow(4096, 0, 0, 0),
			qrow(3, 4, 100, 1000),
			// At the threshold the speed term is dropped.
			wrow(sepc_pkg::CFG_V0, 4),
			qrow(4096, 0, 300, 900),
			// With no band a point exactly on the ellipse sets no flag at all.
			wrow(sepc_pkg::CFG_TOL, 0),
			trow(0, 0, 737, 0, 4'b0000, 737, 1024),
			wrow(sepc_pkg::CFG_STRETCH, 0),
			trow(0, 0, 0, 819, 4'b0000, 737, 819),
			// A zero forward axis reports degenerate with the axes kept.
			wrow(sepc_pkg::CFG_A_MIN, 0),
			trow(0, 0, 5, 5, 4'b0001, 0, 819),
			wrow(sepc_pkg::CFG_B_MIN, 0),
			qrow(100, 0, 5, 5),
			// An unstretched shoulder axis saturates at the signed maximum.
			wrow(sepc_pkg::CFG_B_MIN, 65535),
			qrow(-700, 900, 12, -40000),
			// A write to an unused index changes nothing.
			wrow(CFG_UNUSED, 16'hFFFF),
			qrow(-700, 900, 12, 30000)
		};

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			if (directed[i].is_write)
				write_register(directed[i].idx, directed[i].val);
			else
				offer_query(directed[i].q, directed[i].typed, directed[i].want);
		end

		// Random phases under a spread of settings, extremes among them.
		load_settings(sepc_pkg::RST_A_MIN, sepc_pkg::RST_A_GAIN, sepc_pkg::RST_B_MIN,
			sepc_pkg::RST_B_MAX, 16'd4096, sepc_pkg::RST_STRETCH, sepc_pkg::RST_TOL);
		random_queries(RANDOM_PER_PHASE * 2);
		// Sender pause: the whole pipeline empties before going on.
		query_ch.valid <= 1'b0;
		wait_drained();
		random_queries(RANDOM_PER_PHASE);
		load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF);
		random_queries(RANDOM_PER_PHASE / 2);
		load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 16'd0);
		random_queries(RANDOM_PER_PHASE / 4);
		load_settings(16'd2000, 16'd300, 16'd200, 16'd3000, 16'd800, 1'b1, 16'd400);
		random_queries(RANDOM_PER_PHASE);
		load_settings(16'd500, 16'd4096, 16'd3000, 16'd100, 16'd20000, 1'b1, 16'd10);
		random_queries(RANDOM_PER_PHASE);
		load_settings(16'd1200, 16'd900, 16'd1500, 16'd1500, 16'd5, 1'b0, 16'd100);
		random_queries(RANDOM_PER_PHASE);
		for (int p = 0; p < 3; p++) begin
			load_settings(16'($urandom), 16'($urandom_range(8192, 0)),
				16'($urandom_range(8192, 1)), 16'($urandom_range(8192, 0)),
				16'($urandom_range(16384, 0)), 1'($urandom_range(1, 0)),
				16'($urandom_range(2048, 0)));
			random_queries(RANDOM_PER_PHASE);
		end

		query_ch.valid <= 1'b0;
		wait_drained();
		repeat (PIPE_DRAIN) @(negedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire
